@@ src/aabb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AABB collision resolver package
// Payload types, register indexes and reset values shared by the interfaces
// and the resolver.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int COORD_W   = 32;
  localparam int EXTENT_W  = 31;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_W    = 36;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEET_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SKIN_MARGIN = 3'd5;

  localparam logic [EXTENT_W-1:0] FEET_OFFSET_RESET = 31'd327680;
  localparam logic [EXTENT_W-1:0] SKIN_MARGIN_RESET = 31'd3277;

  typedef struct packed {
    logic                       first;
    logic                       last;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  start_z;
    logic signed [COORD_W-1:0]  start_velocity;
    logic signed [COORD_W-1:0]  box_center_x;
    logic signed [COORD_W-1:0]  box_center_y;
    logic signed [COORD_W-1:0]  box_center_z;
    logic        [EXTENT_W-1:0] box_size_x;
    logic        [EXTENT_W-1:0] box_size_y;
    logic        [EXTENT_W-1:0] box_size_z;
  } box_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] velocity;
    logic                      landed;
    logic                      hit;
    logic                      done_res;
  } player_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [EXTENT_W-1:0]  data;
  } cfg_write_t;

endpackage
`default_nettype wire

@@ src/aabb_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AABB collision resolver channels
// Valid/ready channels for boxes, results and register writes.
// ----------------------------------------------------------------------------
interface aabb_box_if import aabb_pkg::*; ();
  logic      valid;
  logic      ready;
  box_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aabb_res_if import aabb_pkg::*; ();
  logic           valid;
  logic           ready;
  player_result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aabb_cfg_if import aabb_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_write_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/aabb_player_collision_resolver_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AABB player collision resolver
// Pushes the player box out of each overlapping box along the axis of least
// overlap and tracks position, vertical velocity and the landed flag.
//
//   channel  dir  payload          transfer
//   box      in   box_item_t       box.valid && box.ready
//   res      out  player_result_t  res.valid && res.ready
//   cfg      in   cfg_write_t      cfg.valid && cfg.ready (always ready)
//
// One box per cycle while the result channel is not stalled.
// Input register, one pass of add/compare/select logic, result register.
// Player state updates when a box moves into the result register.
// A stalled result holds the pass; the input register still takes one box.
// Synchronous reset clears state and valids and sets config registers to reset values.
// ----------------------------------------------------------------------------
module aabb_player_collision_resolver_unit
  import aabb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  aabb_box_if.sink    box,
  aabb_res_if.source  res,
  aabb_cfg_if.sink    cfg
);

  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t SAT_MAX = WIDE_W'(32'sh7fffffff);
  localparam wide_t SAT_MIN = WIDE_W'(32'sh80000000);

  function automatic wide_t sx(input logic signed [COORD_W-1:0] v);
    sx = {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic wide_t zx(input logic [EXTENT_W-1:0] v);
    zx = {{(WIDE_W-EXTENT_W){1'b0}}, v};
  endfunction

  function automatic wide_t halve(input logic [EXTENT_W-1:0] v);
    halve = {{(WIDE_W-EXTENT_W+1){1'b0}}, v[EXTENT_W-1:1]};
  endfunction

  function automatic wide_t min2(input wide_t a, input wide_t b);
    min2 = (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat(input wide_t v);
    if (v > SAT_MAX) begin
      sat = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      sat = SAT_MIN[COORD_W-1:0];
    end else begin
      sat = v[COORD_W-1:0];
    end
  endfunction

  logic                enabled;
  logic [EXTENT_W-1:0] half_width;
  logic [EXTENT_W-1:0] half_depth;
  logic [EXTENT_W-1:0] head_height;
  logic [EXTENT_W-1:0] feet_offset;
  logic [EXTENT_W-1:0] skin_margin;

  logic signed [COORD_W-1:0] player_x;
  logic signed [COORD_W-1:0] player_y;
  logic signed [COORD_W-1:0] player_z;
  logic signed [COORD_W-1:0] vertical_speed;
  logic                      landed_flag;

  logic           in_valid;
  box_item_t      in_item;
  logic           out_valid;
  player_result_t out_item;

  logic out_free;
  logic advance;

  assign out_free    = !out_valid || res.ready;
  assign advance     = in_valid && out_free;
  assign box.ready   = !in_valid || out_free;
  assign cfg.ready   = 1'b1;
  assign res.valid   = out_valid;
  assign res.payload = out_item;

  logic signed [COORD_W-1:0] px, py, pz, vs;
  logic                      lf;
  wide_t cx, cy, cz, hx, hy, hz;
  wide_t hw, hd, hh, fo, sk;
  wide_t bminx, bmaxx, bminy, bmaxy, bminz, bmaxz;
  wide_t pminx, pmaxx, pminy, pmaxy, pminz, pmaxz;
  wide_t ox, oy, oz;
  logic  overlap;

  logic signed [COORD_W-1:0] player_x_next, player_y_next, player_z_next;
  logic signed [COORD_W-1:0] vertical_speed_next;
  logic                      landed_flag_next;
  logic                      hit_next;

  always_comb begin
    px = in_item.first ? in_item.start_x        : player_x;
    py = in_item.first ? in_item.start_y        : player_y;
    pz = in_item.first ? in_item.start_z        : player_z;
    vs = in_item.first ? in_item.start_velocity : vertical_speed;
    lf = in_item.first ? 1'b0                   : landed_flag;

    cx = sx(in_item.box_center_x);
    cy = sx(in_item.box_center_y);
    cz = sx(in_item.box_center_z);
    hx = halve(in_item.box_size_x);
    hy = halve(in_item.box_size_y);
    hz = halve(in_item.box_size_z);
    hw = zx(half_width);
    hd = zx(half_depth);
    hh = zx(head_height);
    fo = zx(feet_offset);
    sk = zx(skin_margin);

    bminx = cx - hx;
    bmaxx = cx + hx;
    bminy = cy - hy;
    bmaxy = cy + hy;
    bminz = cz - hz;
    bmaxz = cz + hz;
    pminx = sx(px) - hw;
    pmaxx = sx(px) + hw;
    pminy = sx(py) - hd;
    pmaxy = sx(py) + hd;
    pminz = sx(pz) - fo;
    pmaxz = sx(pz) + hh;

    overlap = enabled &&
              (pmaxx > bminx) && (pminx < bmaxx) &&
              (pmaxy > bminy) && (pminy < bmaxy) &&
              (pmaxz > bminz) && (pminz < bmaxz);

    ox = min2(pmaxx - bminx, bmaxx - pminx);
    oy = min2(pmaxy - bminy, bmaxy - pminy);
    oz = min2(pmaxz - bminz, bmaxz - pminz);

    player_x_next       = px;
    player_y_next       = py;
    player_z_next       = pz;
    vertical_speed_next = vs;
    landed_flag_next    = lf;
    hit_next            = overlap;

    if (overlap) begin
      priority if ((ox < oy) && (ox < oz)) begin
        player_x_next = (sx(px) < cx) ? sat(bminx - hw - sk) : sat(bmaxx + hw + sk);
      end else if (oy < oz) begin
        player_y_next = (sx(py) < cy) ? sat(bminy - hd - sk) : sat(bmaxy + hd + sk);
      end else begin
        if (sx(pz) < cz) begin
          player_z_next = sat(bminz - hh - sk);
          if (vs > 0) begin
            vertical_speed_next = '0;
          end
        end else begin
          player_z_next    = sat(bmaxz + fo + sk);
          landed_flag_next = 1'b1;
          if (vs < 0) begin
            vertical_speed_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b1;
      half_width  <= '0;
      half_depth  <= '0;
      head_height <= '0;
      feet_offset <= FEET_OFFSET_RESET;
      skin_margin <= SKIN_MARGIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        REG_ENABLED:     enabled     <= cfg.payload.data[0];
        REG_HALF_WIDTH:  half_width  <= cfg.payload.data;
        REG_HALF_DEPTH:  half_depth  <= cfg.payload.data;
        REG_HEAD_HEIGHT: head_height <= cfg.payload.data;
        REG_FEET_OFFSET: feet_offset <= cfg.payload.data;
        REG_SKIN_MARGIN: skin_margin <= cfg.payload.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      player_x       <= '0;
      player_y       <= '0;
      player_z       <= '0;
      vertical_speed <= '0;
      landed_flag    <= 1'b0;
    end else begin
      if (box.ready) begin
        in_valid <= box.valid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
      if (advance) begin
        player_x       <= player_x_next;
        player_y       <= player_y_next;
        player_z       <= player_z_next;
        vertical_speed <= vertical_speed_next;
        landed_flag    <= landed_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (box.valid && box.ready) begin
      in_item <= box.payload;
    end
    if (advance) begin
      out_item.pos_x    <= player_x_next;
      out_item.pos_y    <= player_y_next;
      out_item.pos_z    <= player_z_next;
      out_item.velocity <= vertical_speed_next;
      out_item.landed   <= landed_flag_next;
      out_item.hit      <= hit_next;
      out_item.done_res <= in_item.last;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !in_valid)
    else $error("valid left set after reset");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid)
    else $error("pending box dropped");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_item.pos_x == player_x) && (out_item.pos_z == player_z) &&
                (out_item.velocity == vertical_speed) && (out_item.landed == landed_flag))
    else $error("result differs from player state");

  a_miss_keeps_state: assert property (@(posedge clk) disable iff (rst)
    advance && !in_item.first && !hit_next |=>
      $stable(player_x) && $stable(player_y) && $stable(player_z) &&
      $stable(vertical_speed) && $stable(landed_flag))
    else $error("state changed without a hit");
`endif

endmodule
`default_nettype wire

@@ verif/aabb_player_collision_resolver_unit_tb.sv @@
// ----------------------------------------------------------------------------
// AABB player collision resolver testbench
// Sends directed and random box streams through the resolver under several
// register settings and flow-control mixes. An in-bench fixed-point model of
// the player state predicts every result, and each result transfer is checked
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module aabb_player_collision_resolver_unit_tb;
  import aabb_pkg::*;

  localparam int ONE = 65536;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int EXT_MAX = 2147483647;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {GEOM_ZERO, GEOM_FULL, GEOM_OFF, GEOM_TYPICAL} geometry_t;

  logic clk;
  logic rst;

  aabb_box_if box_ch();
  aabb_res_if res_ch();
  aabb_cfg_if cfg_ch();

  aabb_player_collision_resolver_unit dut (
    .clk(clk),
    .rst(rst),
    .box(box_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  logic phys_on;
  longint ext_half_width, ext_half_depth, ext_head, ext_feet, ext_skin;
  logic signed [COORD_W-1:0] track_x, track_y, track_z, track_vel;
  logic track_landed;

  player_result_t pending_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic logic signed [COORD_W-1:0] sat_coord(longint v);
    if (v > S32_MAX) return C_MAX;
    if (v < S32_MIN) return C_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic longint least(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  // Advance the player state by one box and return the resulting transfer.
  function automatic player_result_t resolve_box(box_item_t it);
    player_result_t r;
    longint cx, cy, cz, hx, hy, hz, px, py, pz;
    longint bminx, bmaxx, bminy, bmaxy, bminz, bmaxz;
    longint pminx, pmaxx, pminy, pmaxy, pminz, pmaxz;
    longint ox, oy, oz;
    logic overlap;
    overlap = 1'b0;
    if (it.first) begin
      track_x = it.start_x;
      track_y = it.start_y;
      track_z = it.start_z;
      track_vel = it.start_velocity;
      track_landed = 1'b0;
    end
    if (phys_on) begin
      cx = longint'(it.box_center_x);
      cy = longint'(it.box_center_y);
      cz = longint'(it.box_center_z);
      hx = longint'(it.box_size_x >> 1);
      hy = longint'(it.box_size_y >> 1);
      hz = longint'(it.box_size_z >> 1);
      px = longint'(track_x);
      py = longint'(track_y);
      pz = longint'(track_z);
      bminx = cx - hx;
      bmaxx = cx + hx;
      bminy = cy - hy;
      bmaxy = cy + hy;
      bminz = cz - hz;
      bmaxz = cz + hz;
      pminx = px - ext_half_width;
      pmaxx = px + ext_half_width;
      pminy = py - ext_half_depth;
      pmaxy = py + ext_half_depth;
      pminz = pz - ext_feet;
      pmaxz = pz + ext_head;
      if (pmaxx > bminx && pminx < bmaxx && pmaxy > bminy && pminy < bmaxy &&
          pmaxz > bminz && pminz < bmaxz) begin
        overlap = 1'b1;
        ox = least(pmaxx - bminx, bmaxx - pminx);
        oy = least(pmaxy - bminy, bmaxy - pminy);
        oz = least(pmaxz - bminz, bmaxz - pminz);
        if (ox < oy && ox < oz) begin
          if (px < cx) track_x = sat_coord(bminx - ext_half_width - ext_skin);
          else track_x = sat_coord(bmaxx + ext_half_width + ext_skin);
        end else if (oy < oz) begin
          if (py < cy) track_y = sat_coord(bminy - ext_half_depth - ext_skin);
          else track_y = sat_coord(bmaxy + ext_half_depth + ext_skin);
        end else if (pz < cz) begin
          track_z = sat_coord(bminz - ext_head - ext_skin);
          if (track_vel > 0) track_vel = '0;
        end else begin
          track_z = sat_coord(bmaxz + ext_feet + ext_skin);
          track_landed = 1'b1;
          if (track_vel < 0) track_vel = '0;
        end
      end
    end
    r.pos_x = track_x;
    r.pos_y = track_y;
    r.pos_z = track_z;
    r.velocity = track_vel;
    r.landed = track_landed;
    r.hit = overlap;
    r.done_res = it.last;
    return r;
  endfunction

  function automatic box_item_t make_box(
    logic first, logic last,
    logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
    logic signed [COORD_W-1:0] sz, logic signed [COORD_W-1:0] sv,
    logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
    logic signed [COORD_W-1:0] cz,
    int wx, int wy, int wz);
    box_item_t it;
    it.first = first;
    it.last = last;
    it.start_x = sx;
    it.start_y = sy;
    it.start_z = sz;
    it.start_velocity = sv;
    it.box_center_x = cx;
    it.box_center_y = cy;
    it.box_center_z = cz;
    it.box_size_x = EXTENT_W'(wx);
    it.box_size_y = EXTENT_W'(wy);
    it.box_size_z = EXTENT_W'(wz);
    return it;
  endfunction

  function automatic longint pick_span();
    int r;
    r = $urandom_range(9);
    if (r < 7) return longint'(1) << $urandom_range(12, 19);
    if (r < 9) return longint'(1) << $urandom_range(20, 26);
    return longint'(1) << $urandom_range(27, 29);
  endfunction

  function automatic logic signed [COORD_W-1:0] near_coord(
    logic signed [COORD_W-1:0] base, longint span);
    return sat_coord(longint'(base) + longint'($urandom_range(0, 32'(2 * span))) - span);
  endfunction

  function automatic logic [EXTENT_W-1:0] extent_near(longint span);
    longint hi;
    hi = (4 * span > longint'(EXT_MAX)) ? longint'(EXT_MAX) : 4 * span;
    return EXTENT_W'($urandom_range(32'(span), 32'(hi)));
  endfunction

  // Mostly well-formed passes around the player; some noise and broken flags.
  function automatic box_item_t random_box(logic want_first, logic want_last);
    box_item_t it;
    longint span;
    logic signed [COORD_W-1:0] ax, ay, az;
    if ($urandom_range(99) < 12) begin
      it.first = 1'($urandom_range(1));
      it.last = 1'($urandom_range(1));
      it.start_x = $urandom;
      it.start_y = $urandom;
      it.start_z = $urandom;
      it.start_velocity = $urandom;
      it.box_center_x = $urandom;
      it.box_center_y = $urandom;
      it.box_center_z = $urandom;
      it.box_size_x = EXTENT_W'($urandom);
      it.box_size_y = EXTENT_W'($urandom);
      it.box_size_z = EXTENT_W'($urandom);
      return it;
    end
    it.first = want_first ^ ($urandom_range(99) < 8);
    it.last = want_last ^ ($urandom_range(99) < 8);
    it.start_x = near_coord(track_x, pick_span());
    it.start_y = near_coord(track_y, pick_span());
    it.start_z = near_coord(track_z, pick_span());
    it.start_velocity = near_coord('0, pick_span());
    ax = it.first ? it.start_x : track_x;
    ay = it.first ? it.start_y : track_y;
    az = it.first ? it.start_z : track_z;
    span = pick_span();
    it.box_center_x = near_coord(ax, span);
    it.box_center_y = near_coord(ay, span);
    it.box_center_z = near_coord(az, span);
    it.box_size_x = extent_near(span);
    it.box_size_y = extent_near(span);
    it.box_size_z = extent_near(span);
    return it;
  endfunction

  task automatic send_box(box_item_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      box_ch.valid <= 1'b0;
      @(negedge clk);
    end
    box_ch.valid <= 1'b1;
    box_ch.payload <= item;
    @(posedge clk);
    while (!box_ch.ready) @(posedge clk);
    pending_results.push_back(resolve_box(item));
    @(negedge clk);
  endtask

  task automatic drain_results();
    box_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EXTENT_W-1:0] data);
    cfg_write_t w;
    w.index = idx;
    w.data = data;
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ENABLED: phys_on = data[0];
      REG_HALF_WIDTH: ext_half_width = longint'(data);
      REG_HALF_DEPTH: ext_half_depth = longint'(data);
      REG_HEAD_HEIGHT: ext_head = longint'(data);
      REG_FEET_OFFSET: ext_feet = longint'(data);
      REG_SKIN_MARGIN: ext_skin = longint'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(logic en, int hw, int hd, int head, int feet, int skin);
    write_reg(REG_ENABLED, {{(EXTENT_W-1){1'b0}}, en});
    write_reg(REG_HALF_WIDTH, EXTENT_W'(hw));
    write_reg(REG_HALF_DEPTH, EXTENT_W'(hd));
    write_reg(REG_HEAD_HEIGHT, EXTENT_W'(head));
    write_reg(REG_FEET_OFFSET, EXTENT_W'(feet));
    write_reg(REG_SKIN_MARGIN, EXTENT_W'(skin));
  endtask

  task automatic randomize_geometry(geometry_t kind);
    int hw, hd, head, feet, skin;
    hw = int'($urandom_range(4 * ONE));
    hd = int'($urandom_range(4 * ONE));
    head = int'($urandom_range(8 * ONE));
    feet = int'($urandom_range(8 * ONE));
    skin = int'($urandom_range(ONE / 4));
    case (kind)
      GEOM_ZERO: set_geometry(1'b1, 0, 0, 0, 0, 0);
      GEOM_FULL: set_geometry(1'b1, EXT_MAX, EXT_MAX, EXT_MAX, EXT_MAX, EXT_MAX);
      GEOM_OFF: set_geometry(1'b0, hw, hd, head, feet, skin);
      default: set_geometry(1'b1, hw, hd, head, feet, skin);
    endcase
  endtask

  task automatic test_reset_values();
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, -ONE, 0, 0, -11 * ONE / 2,
                      20 * ONE, 20 * ONE, 2 * ONE));
    send_box(make_box(1'b0, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  task automatic test_resolve_axes();
    set_geometry(1'b1, ONE, ONE, 2 * ONE, 2 * ONE, 3277);
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, -3 * ONE, 0, 0, -3 * ONE,
                      10 * ONE, 10 * ONE, 4 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, 3 * ONE, 0, 0, 3 * ONE,
                      10 * ONE, 10 * ONE, 4 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, 0, -2 * ONE, 0, 0, 4 * ONE, 20 * ONE, 20 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, 0, 2 * ONE, 0, 0, 4 * ONE, 20 * ONE, 20 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, 0, 0, -2 * ONE, 0, 20 * ONE, 4 * ONE, 20 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, 0, 0, 2 * ONE, 0, 20 * ONE, 4 * ONE, 20 * ONE));
    // touching faces do not overlap
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, 0, 3 * ONE, 0, 0, 4 * ONE, 20 * ONE, 20 * ONE));
    // player centered on the box goes to the positive side
    send_box(make_box(1'b1, 1'b0, 5 * ONE, -7 * ONE, ONE, -ONE, 5 * ONE, -7 * ONE, ONE,
                      2 * ONE, 20 * ONE, 20 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, -ONE, 0, 0, 0, 20 * ONE, 20 * ONE, 2 * ONE));
    // held state carries over when first is missing
    send_box(make_box(1'b0, 1'b0, 12345, -54321, 777, -9, 0, 0, 0,
                      20 * ONE, 20 * ONE, 20 * ONE));
    send_box(make_box(1'b0, 1'b1, 0, 0, 0, 0, ONE, ONE, 3 * ONE, 4 * ONE, 4 * ONE, 4 * ONE));
    drain_results();
  endtask

  task automatic test_tie_breaks();
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, 0, -2 * ONE, -2 * ONE, 0,
                      4 * ONE, 4 * ONE, 20 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, -ONE, 0, -2 * ONE, -3 * ONE,
                      20 * ONE, 4 * ONE, 4 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, -ONE, -2 * ONE, -2 * ONE, -3 * ONE,
                      4 * ONE, 4 * ONE, 4 * ONE));
    send_box(make_box(1'b1, 1'b1, 0, 0, 0, 0, -5 * ONE / 2, -2 * ONE, -3 * ONE,
                      4 * ONE, 4 * ONE, 4 * ONE));
    drain_results();
  endtask

  task automatic test_saturation();
    set_geometry(1'b1, ONE, ONE, 2 * ONE, 2 * ONE, ONE);
    send_box(make_box(1'b1, 1'b0, 32'sh7FFFFFF0, 0, 0, 0, 32'sh7FFFFFF0, 0, 0,
                      4 * ONE, 20 * ONE, 20 * ONE));
    send_box(make_box(1'b1, 1'b0, 32'sh80000010, 0, 0, 0, 32'sh80000011, 0, 0,
                      4 * ONE, 20 * ONE, 20 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 32'sh7FFFFF00, C_MIN, 0, 0, 32'sh7FFFFF00,
                      20 * ONE, 20 * ONE, 2 * ONE));
    send_box(make_box(1'b1, 1'b0, 0, 0, 32'sh80000100, C_MAX, 0, 0, 32'sh80000101,
                      20 * ONE, 20 * ONE, 2 * ONE));
    drain_results();
    set_geometry(1'b1, EXT_MAX, EXT_MAX, EXT_MAX, EXT_MAX, EXT_MAX);
    send_box(make_box(1'b1, 1'b1, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN,
                      EXT_MAX, EXT_MAX, EXT_MAX));
    send_box(make_box(1'b1, 1'b0, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX,
                      0, 0, 0));
    send_box(make_box(1'b0, 1'b1, 0, 0, 0, 0, 0, 0, 0, EXT_MAX, 0, EXT_MAX));
    drain_results();
  endtask

  task automatic test_disabled_passthrough();
    set_geometry(1'b1, ONE, ONE, 2 * ONE, 2 * ONE, 3277);
    send_box(make_box(1'b1, 1'b0, 0, 0, 0, -ONE, 0, 0, -3 * ONE, 10 * ONE, 10 * ONE, 4 * ONE));
    drain_results();
    write_reg(REG_ENABLED, '0);
    send_box(make_box(1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 0, 20 * ONE, 20 * ONE, 20 * ONE));
    send_box(make_box(1'b1, 1'b1, 3 * ONE, -ONE, ONE, 2 * ONE, 3 * ONE, -ONE, ONE,
                      20 * ONE, 20 * ONE, 20 * ONE));
    drain_results();
  endtask

  task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct,
                                     geometry_t kind);
    int sent;
    int pass_len;
    randomize_geometry(kind);
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pass_len = $urandom_range(1, 8);
      for (int k = 0; k < pass_len; k++) begin
        send_box(random_box(k == 0, k == pass_len - 1));
        sent++;
      end
    end
    drain_results();
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  task automatic check_field(string name, logic signed [COORD_W-1:0] want,
                             logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    player_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no box pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("pos_x", want.pos_x, res_ch.payload.pos_x);
        check_field("pos_y", want.pos_y, res_ch.payload.pos_y);
        check_field("pos_z", want.pos_z, res_ch.payload.pos_z);
        check_field("velocity", want.velocity, res_ch.payload.velocity);
        check_field("landed", COORD_W'(want.landed), COORD_W'(res_ch.payload.landed));
        check_field("hit", COORD_W'(want.hit), COORD_W'(res_ch.payload.hit));
        check_field("done_res", COORD_W'(want.done_res), COORD_W'(res_ch.payload.done_res));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("aabb_player_collision_resolver_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    box_ch.valid = 1'b0;
    box_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    phys_on = 1'b1;
    ext_half_width = 0;
    ext_half_depth = 0;
    ext_head = 0;
    ext_feet = longint'(FEET_OFFSET_RESET);
    ext_skin = longint'(SKIN_MARGIN_RESET);
    track_x = '0;
    track_y = '0;
    track_z = '0;
    track_vel = '0;
    track_landed = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_resolve_axes();
    test_tie_breaks();
    test_saturation();
    test_disabled_passthrough();
    test_random_traffic(350, 0, 0, GEOM_TYPICAL);
    test_random_traffic(350, 63, 0, GEOM_TYPICAL);
    test_random_traffic(350, 0, 63, GEOM_TYPICAL);
    test_random_traffic(350, 30, 30, GEOM_TYPICAL);
    test_random_traffic(250, 30, 30, GEOM_ZERO);
    test_random_traffic(150, 63, 0, GEOM_FULL);
    test_random_traffic(100, 0, 63, GEOM_OFF);
    test_random_traffic(100, 0, 0, GEOM_TYPICAL);

    if (error_count == 0) begin
      $display("aabb_player_collision_resolver_unit regression: pass");
    end else begin
      $display("aabb_player_collision_resolver_unit regression: fail");
    end
    $finish;
  end

endmodule
